/* rtl/lsact_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsact_pkg
// Types and codes shared by the LRU set-associative cache tag store.
// ----------------------------------------------------------------------------
package lsact_pkg;

    // Width of the byte address that a request carries.
    localparam int ADDR_WIDTH  = 32;
    localparam int STAMP_WIDTH = 32;
    localparam int COUNT_WIDTH = 32;

    // Access kinds.
    localparam logic [1:0] MODE_FETCH  = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_STORE  = 2'd2;
    localparam logic [1:0] MODE_MODIFY = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WAYS_USED  = 2'd2;

    typedef struct packed {
        logic [1:0]            mode;
        logic [ADDR_WIDTH-1:0] address;
    } req_t;

    typedef struct packed {
        logic                   hit;
        logic                   miss;
        logic                   eviction;
        logic                   modify_hit;
        logic [COUNT_WIDTH-1:0] hit_total;
        logic [COUNT_WIDTH-1:0] miss_total;
        logic [COUNT_WIDTH-1:0] evict_total;
    } rsp_t;

    // One way of a set as held in the line memory.
    typedef struct packed {
        logic [ADDR_WIDTH-1:0]  tag;
        logic [STAMP_WIDTH-1:0] stamp;
    } line_t;

endpackage
`default_nettype wire

/* rtl/lsact_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsact_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module lsact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/lru_set_assoc_cache_tags.sv */
`timescale 1ns / 1ps
`default_nettype none
// A load, store or modify word has its set row read from the line memory at the
// accepting edge; compare and update follow in the look state once the output
// register is free. No new word is taken until that read-modify-write of the
// set row is done; instruction fetches are taken every cycle while idle.
// Reset clears the valid bits, counters and access clock at once and loads the
// register defaults; there is no clearing pass, the block is ready right away.
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_tags
// Tag store of a set-associative cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
module lru_set_assoc_cache_tags #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 4
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    req_valid,
    output logic                                         req_ready,
    input  wire lsact_pkg::req_t                         req,
    output logic                                         rsp_valid,
    input  wire logic                                    rsp_ready,
    output lsact_pkg::rsp_t                              rsp,
    input  wire logic                                    cfg_we,
    input  wire logic [lsact_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [lsact_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    // Sizes derived from the parameters.
    localparam int SET_COUNT = 1 << MAX_SET_BITS;
    localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_W    = $bits(lsact_pkg::line_t);
    localparam int ROW_W     = WAYS * LINE_W;
    localparam int SEFF_W    = $clog2(MAX_SET_BITS + 1) + 1;
    localparam int SHIFT_W   = 7;

    // Two-state sequencer: wait for a word, then finish it against the row
    // that the line memory returns.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

    typedef lsact_pkg::line_t row_t [WAYS];

    state_t state_reg, state_next;

    // Configuration registers.
    logic [2:0] index_bits_reg;
    logic [4:0] block_bits_reg;
    logic [2:0] ways_used_reg;

    // Per-word registers captured when a data access is accepted.
    logic [SET_W-1:0]                  set_reg;
    logic [lsact_pkg::ADDR_WIDTH-1:0]  tag_reg;
    logic                              modify_reg;

    // Global state.
    logic [SET_COUNT-1:0][WAYS-1:0]      valid_reg;
    logic [lsact_pkg::STAMP_WIDTH-1:0]   clock_reg;
    logic [lsact_pkg::COUNT_WIDTH-1:0]   hit_cnt_reg;
    logic [lsact_pkg::COUNT_WIDTH-1:0]   miss_cnt_reg;
    logic [lsact_pkg::COUNT_WIDTH-1:0]   evict_cnt_reg;

    logic             rsp_valid_reg;
    lsact_pkg::rsp_t  rsp_reg;

    // Address split.
    logic [SEFF_W-1:0]                 s_eff;
    logic [SHIFT_W-1:0]                tag_shift;
    logic [lsact_pkg::ADDR_WIDTH-1:0]  addr_shifted;
    logic [SET_W-1:0]                  set_next;
    logic [lsact_pkg::ADDR_WIDTH-1:0]  tag_next;

    // Lookup and update.
    logic [ROW_W-1:0]                  rd_row;
    logic [ROW_W-1:0]                  wr_row;
    row_t                              row;
    row_t                              new_row;
    logic [WAYS-1:0]                   way_en;
    logic [WAYS-1:0]                   vrow;
    logic                              hit_found;
    logic [WAY_W-1:0]                  hit_way;
    logic                              inv_found;
    logic [WAY_W-1:0]                  inv_way;
    logic [WAY_W-1:0]                  lru_way;
    logic [WAY_W-1:0]                  upd_way;
    logic                              evict;
    logic [lsact_pkg::STAMP_WIDTH-1:0] clock_next;
    logic [lsact_pkg::COUNT_WIDTH-1:0] hit_cnt_next;
    logic [lsact_pkg::COUNT_WIDTH-1:0] miss_cnt_next;
    logic [lsact_pkg::COUNT_WIDTH-1:0] evict_cnt_next;

    logic accept;
    logic lookup;
    logic finish;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    // Only data accesses go to the line memory; fetches are dropped on accept.
    assign lookup    = accept && (req.mode != lsact_pkg::MODE_FETCH);
    // The word completes once the output register is free or being emptied.
    assign finish    = (state_reg == ST_LOOK) && (!rsp_valid_reg || rsp_ready);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Address split. A set index width above MAX_SET_BITS acts as the
    // maximum. A shift that runs past the address leaves a zero tag.
    // ------------------------------------------------------------------
    always_comb
    begin
        if ({29'd0, index_bits_reg} > MAX_SET_BITS)
        begin
            s_eff = SEFF_W'(MAX_SET_BITS);
        end
        else
        begin
            s_eff = SEFF_W'(index_bits_reg);
        end
        tag_shift    = SHIFT_W'(s_eff) + SHIFT_W'(block_bits_reg);
        addr_shifted = req.address >> block_bits_reg;
        tag_next     = req.address >> tag_shift;
        for (int i = 0; i < SET_W; i++)
        begin
            set_next[i] = addr_shifted[i] && (i < int'(s_eff));
        end
    end

    // ------------------------------------------------------------------
    // Line memory: one row per set, all ways side by side.
    // ------------------------------------------------------------------
    lsact_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SET_COUNT)
    ) u_line_ram (
        .clk   (clk),
        .we    (finish),
        .waddr (set_reg),
        .wdata (wr_row),
        .re    (lookup),
        .raddr (set_next),
        .rdata (rd_row)
    );

    // ------------------------------------------------------------------
    // Compare all enabled ways of the set. A way count of zero acts as one
    // and a count above WAYS acts as WAYS, which the enable mask gives.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [lsact_pkg::STAMP_WIDTH-1:0] min_stamp;

        for (int w = 0; w < WAYS; w++)
        begin
            row[w]    = rd_row[w*LINE_W +: LINE_W];
            way_en[w] = (w == 0) || ({29'd0, ways_used_reg} > 32'(w));
        end
        vrow = valid_reg[set_reg];

        hit_found = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_found && way_en[w] && vrow[w] && (row[w].tag == tag_reg))
            begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (!inv_found && way_en[w] && !vrow[w])
            begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(w);
            end
        end

        // Oldest stamp wins; strict compare keeps the lowest way on a tie.
        lru_way   = '0;
        min_stamp = row[0].stamp;
        for (int w = 1; w < WAYS; w++)
        begin
            if (way_en[w] && (row[w].stamp < min_stamp))
            begin
                lru_way   = WAY_W'(w);
                min_stamp = row[w].stamp;
            end
        end

        evict      = !hit_found && !inv_found;
        clock_next = clock_reg + 1'b1;

        if (hit_found)
        begin
            upd_way = hit_way;
        end
        else if (inv_found)
        begin
            upd_way = inv_way;
        end
        else
        begin
            upd_way = lru_way;
        end

        new_row = row;
        new_row[upd_way].stamp = clock_next;
        if (!hit_found)
        begin
            new_row[upd_way].tag = tag_reg;
        end
        for (int w = 0; w < WAYS; w++)
        begin
            wr_row[w*LINE_W +: LINE_W] = new_row[w];
        end

        hit_cnt_next   = hit_cnt_reg + lsact_pkg::COUNT_WIDTH'(hit_found)
                       + lsact_pkg::COUNT_WIDTH'(modify_reg);
        miss_cnt_next  = miss_cnt_reg + lsact_pkg::COUNT_WIDTH'(!hit_found);
        evict_cnt_next = evict_cnt_reg + lsact_pkg::COUNT_WIDTH'(evict);
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (lookup)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            index_bits_reg <= 3'd1;
            block_bits_reg <= 5'd1;
            ways_used_reg  <= 3'd1;
            valid_reg      <= '0;
            clock_reg      <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            evict_cnt_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    lsact_pkg::CFG_SET_BITS:   index_bits_reg <= cfg_data[2:0];
                    lsact_pkg::CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                    lsact_pkg::CFG_WAYS_USED:  ways_used_reg  <= cfg_data[2:0];
                    default:
                    begin
                    end
                endcase
            end

            if (finish)
            begin
                valid_reg[set_reg][upd_way] <= 1'b1;
                clock_reg     <= clock_next;
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (lookup)
        begin
            set_reg    <= set_next;
            tag_reg    <= tag_next;
            modify_reg <= (req.mode == lsact_pkg::MODE_MODIFY);
        end
        if (finish)
        begin
            rsp_reg.hit         <= hit_found;
            rsp_reg.miss        <= !hit_found;
            rsp_reg.eviction    <= evict;
            rsp_reg.modify_hit  <= modify_reg;
            rsp_reg.hit_total   <= hit_cnt_next;
            rsp_reg.miss_total  <= miss_cnt_next;
            rsp_reg.evict_total <= evict_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_hit_xor_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.hit != rsp.miss))
        else $error("result word is not exactly one of hit and miss");

    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.eviction) |-> rsp.miss)
        else $error("eviction reported on a hit");

    a_lookup_next: assert property (@(posedge clk) disable iff (!rst_n)
        lookup |=> (state_reg == ST_LOOK))
        else $error("data access accepted without a lookup cycle");

    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (rsp_valid && (state_reg == ST_IDLE)))
        else $error("finished lookup did not load the output register");

endmodule
`default_nettype wire

/* test/lru_set_assoc_cache_tags_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_tags_tb
// Self-checking bench for the LRU set-associative cache tag store. A short
// stimulus table covers reset defaults, address extremes, LRU order and odd
// register values. Random phases with fresh register settings follow. Every
// response word is checked against a hand-computed value or a tag store model.
// ----------------------------------------------------------------------------
module lru_set_assoc_cache_tags_tb;

    // Geometry handed to the block. It must match the model below.
    localparam int SET_LIMIT    = 6;
    localparam int WAY_COUNT    = 4;
    localparam int LINE_TOTAL   = (1 << SET_LIMIT) * WAY_COUNT;
    localparam int RANDOM_ITEMS = 1350;
    localparam int REPORT_LIMIT = 10;
    localparam int DATA_W       = lsact_pkg::CFG_DATA_WIDTH;
    localparam int INDEX_W      = lsact_pkg::CFG_INDEX_WIDTH;
    // Settle time after the last response before a register write. This covers
    // any word that may still be in flight.
    localparam int SETTLE_CYCLES = 6;

    // Register index 3 is not mapped. A write to it must change nothing.
    localparam logic [INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

    // ------------------------------------------------------------------------
    // Signals to and from the block. The ones the bench drives are known from time zero.
    // ------------------------------------------------------------------------
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_ready;
    lsact_pkg::req_t            req       = '0;
    logic                       rsp_valid;
    logic                       rsp_ready = 1'b0;
    lsact_pkg::rsp_t            rsp;
    logic                       cfg_we    = 1'b0;
    logic [INDEX_W-1:0]         cfg_index = '0;
    logic [DATA_W-1:0]          cfg_data  = '0;

    lru_set_assoc_cache_tags #(
        .MAX_SET_BITS (SET_LIMIT),
        .WAYS         (WAY_COUNT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Local copy of the tag store: lines, stamps, access clock, totals and the
    // three registers. It advances once for every load, store or modify word the block takes.
    // ------------------------------------------------------------------------
    bit          line_live   [LINE_TOTAL];
    logic [31:0] line_tags   [LINE_TOTAL];
    logic [31:0] line_stamps [LINE_TOTAL];
    logic [31:0] access_count;
    logic [31:0] hits_so_far;
    logic [31:0] misses_so_far;
    logic [31:0] evictions_so_far;
    logic [2:0]  index_bits_reg;
    logic [4:0]  block_bits_reg;
    logic [2:0]  ways_reg;

    // Response words still owed by the block, oldest first.
    lsact_pkg::rsp_t pending_rsp[$];

    int  mismatch_count = 0;
    int  rsp_count      = 0;
    // When set, the sender sends back to back and the receiver never stalls.
    bit  calm           = 1'b0;

    function automatic void clear_tag_model();
        for (int n = 0; n < LINE_TOTAL; n++)
        begin
            line_live[n]   = 1'b0;
            line_tags[n]   = '0;
            line_stamps[n] = '1;
        end
        access_count     = '0;
        hits_so_far      = '0;
        misses_so_far    = '0;
        evictions_so_far = '0;
        index_bits_reg   = 3'd1;
        block_bits_reg   = 5'd1;
        ways_reg         = 3'd1;
    endfunction

    function automatic void apply_register(input logic [INDEX_W-1:0] idx,
                                           input logic [DATA_W-1:0] val);
        case (idx)
            lsact_pkg::CFG_SET_BITS:   index_bits_reg = val[2:0];
            lsact_pkg::CFG_BLOCK_BITS: block_bits_reg = val;
            lsact_pkg::CFG_WAYS_USED:  ways_reg       = val[2:0];
            default:        ;
        endcase
    endfunction

    // Register values as the block uses them. Out-of-range values saturate.
    function automatic int active_index_bits();
        return (index_bits_reg > SET_LIMIT) ? SET_LIMIT : int'(index_bits_reg);
    endfunction

    function automatic int active_ways();
        if (ways_reg == 0)
            return 1;
        return (ways_reg > WAY_COUNT) ? WAY_COUNT : int'(ways_reg);
    endfunction

    // Looks one access up in the model and updates it. The return value is 0
    // for an instruction fetch, which leaves the store untouched and gives no
    // response word.
    function automatic bit lookup_line(input lsact_pkg::req_t w,
                                       output lsact_pkg::rsp_t r);
        logic [63:0] addr64;
        logic [63:0] tag64;
        logic [63:0] set64;
        int          s;
        int          e;
        int          base;
        int          victim;
        bit          hit;
        bit          found_free;
        bit          evicted;
        r = '0;
        if (w.mode == lsact_pkg::MODE_FETCH)
            return 1'b0;
        s = active_index_bits();
        e = active_ways();
        access_count = access_count + 1;
        addr64 = {32'b0, w.address};
        // Shifts can reach 37 bits, so the split is done at 64 bits.
        tag64  = addr64 >> (s + int'(block_bits_reg));
        set64  = (addr64 >> block_bits_reg) & ((64'd1 << s) - 64'd1);
        base   = int'(set64) * WAY_COUNT;
        hit        = 1'b0;
        found_free = 1'b0;
        evicted    = 1'b0;
        victim     = 0;
        for (int way = 0; way < e; way++)
        begin
            if (!hit && line_live[base + way] && line_tags[base + way] == tag64[31:0])
            begin
                line_stamps[base + way] = access_count;
                hit = 1'b1;
            end
        end
        if (!hit)
        begin
            for (int way = 0; way < e; way++)
            begin
                if (!found_free && !line_live[base + way])
                begin
                    victim     = way;
                    found_free = 1'b1;
                end
            end
            // All ways valid: the oldest stamp loses, the lowest way on a tie.
            if (!found_free)
            begin
                for (int way = 1; way < e; way++)
                begin
                    if (line_stamps[base + way] < line_stamps[base + victim])
                        victim = way;
                end
            end
            evicted = line_live[base + victim];
            line_tags[base + victim]   = tag64[31:0];
            line_live[base + victim]   = 1'b1;
            line_stamps[base + victim] = access_count;
        end
        if (hit)
            hits_so_far = hits_so_far + 1;
        else
            misses_so_far = misses_so_far + 1;
        if (evicted)
            evictions_so_far = evictions_so_far + 1;
        // The store half of a modify always hits.
        if (w.mode == lsact_pkg::MODE_MODIFY)
            hits_so_far = hits_so_far + 1;
        r.hit         = hit;
        r.miss        = !hit;
        r.eviction    = evicted;
        r.modify_hit  = (w.mode == lsact_pkg::MODE_MODIFY);
        r.hit_total   = hits_so_far;
        r.miss_total  = misses_so_far;
        r.evict_total = evictions_so_far;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus table. A row is either a register write or a request word. A
    // few request rows carry a hand-computed response. The model covers the
    // rest.
    // ------------------------------------------------------------------------
    typedef struct {
        bit                         is_write;
        logic [INDEX_W-1:0]         reg_index;
        logic [DATA_W-1:0]          reg_value;
        lsact_pkg::req_t            word;
        bit                         known;
        lsact_pkg::rsp_t            want;
    } plan_row_t;

    plan_row_t directed_plan[$];

    function automatic void plan_write(input logic [INDEX_W-1:0] idx,
                                       input logic [DATA_W-1:0] val);
        plan_row_t row;
        row           = '{default: '0};
        row.is_write  = 1'b1;
        row.reg_index = idx;
        row.reg_value = val;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_word(input logic [1:0] mode, input logic [31:0] addr);
        plan_row_t row;
        row              = '{default: '0};
        row.word.mode    = mode;
        row.word.address = addr;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_known(input logic [1:0] mode, input logic [31:0] addr,
                                       input bit hit, input bit miss, input bit evicted,
                                       input bit modified, input int hits, input int misses,
                                       input int evictions);
        plan_row_t row;
        row                  = '{default: '0};
        row.word.mode        = mode;
        row.word.address     = addr;
        row.known            = 1'b1;
        row.want.hit         = hit;
        row.want.miss        = miss;
        row.want.eviction    = evicted;
        row.want.modify_hit  = modified;
        row.want.hit_total   = hits;
        row.want.miss_total  = misses;
        row.want.evict_total = evictions;
        directed_plan.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // Random choices.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [1:0] pick_mode();
        if ($urandom_range(0, 19) < 3)
            return lsact_pkg::MODE_FETCH;
        case ($urandom_range(0, 2))
            0:       return lsact_pkg::MODE_LOAD;
            1:       return lsact_pkg::MODE_STORE;
            default: return lsact_pkg::MODE_MODIFY;
        endcase
    endfunction

    // Most addresses are built from a small tag and a low set so that sets fill
    // up, hit and evict. Some use a random tag, and some are fully random.
    function automatic logic [31:0] pick_address();
        logic [63:0] tag_part;
        logic [63:0] addr64;
        int          s;
        int          b;
        int          set_top;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        s = active_index_bits();
        b = int'(block_bits_reg);
        if ($urandom_range(0, 4) == 0)
            tag_part = 64'($urandom);
        else
            tag_part = 64'($urandom_range(0, active_ways() + 2));
        set_top = (1 << s) - 1;
        if (set_top > 3 && $urandom_range(0, 3) != 0)
            set_top = 3;
        addr64 = (tag_part << (s + b))
               | (64'($urandom_range(0, set_top)) << b)
               | (64'($urandom) & ((64'd1 << b) - 64'd1));
        return addr64[31:0];
    endfunction

    function automatic logic [DATA_W-1:0] pick_index_bits();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return DATA_W'($urandom_range(0, 3));
        if (roll < 85)
            return DATA_W'($urandom_range(4, 7));
        return DATA_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [DATA_W-1:0] pick_block_bits();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return DATA_W'($urandom_range(0, 4));
        if (roll < 85)
            return DATA_W'($urandom_range(5, 25));
        return DATA_W'($urandom_range(26, 31));
    endfunction

    function automatic logic [DATA_W-1:0] pick_ways();
        if ($urandom_range(0, 9) < 6)
            return DATA_W'($urandom_range(1, 4));
        return DATA_W'($urandom_range(0, 31));
    endfunction

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------

    // Offers one request word after an optional gap and waits until it is
    // taken. The model advances at the accepting edge. Valid is lowered only
    // when a gap follows, so it never drops and rises in the same step.
    task automatic send_word(input lsact_pkg::req_t w, input int gap, output bit has,
                             output lsact_pkg::rsp_t r);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        has = lookup_line(w, r);
    endtask

    // Stops sending and waits until every owed response has come. It then
    // waits out the pipeline so that no word is still in flight.
    task automatic settle_idle();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write. The write enable is dropped for a cycle afterward,
    // so that back-to-back writes never assign it twice in one step.
    task automatic write_register(input logic [INDEX_W-1:0] idx,
                                  input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_register(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        lsact_pkg::req_t w;
        lsact_pkg::rsp_t r;
        bit   has;
        int   phase;
        int   phase_len;
        int   pause_at;
        int   sent_items;
        clear_tag_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 1 set bit, 1 block bit and a single way.
        // With one way, any new tag in a set evicts the line held there.
        plan_word(lsact_pkg::MODE_FETCH, 32'h0000_0000);
        plan_known(lsact_pkg::MODE_LOAD,   32'h0000_0000, 0, 1, 0, 0, 0, 1, 0);
        plan_known(lsact_pkg::MODE_LOAD,   32'h0000_0001, 1, 0, 0, 0, 1, 1, 0);
        plan_known(lsact_pkg::MODE_STORE,  32'h0000_0002, 0, 1, 0, 0, 1, 2, 0);
        plan_known(lsact_pkg::MODE_MODIFY, 32'h0000_0000, 1, 0, 0, 1, 3, 2, 0);
        plan_known(lsact_pkg::MODE_LOAD,   32'h0000_0004, 0, 1, 1, 0, 3, 3, 1);
        plan_known(lsact_pkg::MODE_LOAD,   32'hFFFF_FFFF, 0, 1, 1, 0, 3, 4, 2);
        plan_known(lsact_pkg::MODE_MODIFY, 32'hFFFF_FFFF, 1, 0, 0, 1, 5, 4, 2);
        plan_word(lsact_pkg::MODE_FETCH, 32'hFFFF_FFFF);
        plan_known(lsact_pkg::MODE_MODIFY, 32'h0000_0008, 0, 1, 1, 1, 6, 5, 3);
        // A single set with four ways, filled and then replaced in LRU order.
        // The lines left by the reset settings are reread under the new split.
        plan_write(lsact_pkg::CFG_SET_BITS, 5'd0);
        plan_write(lsact_pkg::CFG_BLOCK_BITS, 5'd0);
        plan_write(lsact_pkg::CFG_WAYS_USED, 5'd4);
        plan_word(lsact_pkg::MODE_LOAD, 32'd0);
        plan_word(lsact_pkg::MODE_LOAD, 32'd1);
        plan_word(lsact_pkg::MODE_LOAD, 32'd2);
        plan_word(lsact_pkg::MODE_LOAD, 32'd3);
        plan_word(lsact_pkg::MODE_LOAD, 32'd0);
        plan_word(lsact_pkg::MODE_LOAD, 32'd4);
        plan_word(lsact_pkg::MODE_STORE, 32'd1);
        plan_word(lsact_pkg::MODE_MODIFY, 32'd2);
        // Set bits too large and ways above the limit saturate. The widest
        // block offset leaves a zero tag, with only the top address bit in the set index.
        // The unmapped index is also written.
        plan_write(lsact_pkg::CFG_SET_BITS, 5'h1F);
        plan_write(lsact_pkg::CFG_BLOCK_BITS, 5'd31);
        plan_write(lsact_pkg::CFG_WAYS_USED, 5'd7);
        plan_write(CFG_UNMAPPED, 5'h1F);
        plan_word(lsact_pkg::MODE_LOAD, 32'hFFFF_FFFF);
        plan_word(lsact_pkg::MODE_LOAD, 32'h8000_0000);
        plan_word(lsact_pkg::MODE_LOAD, 32'h0000_0000);
        // A way count of zero acts as a single way.
        plan_write(lsact_pkg::CFG_WAYS_USED, 5'd0);
        plan_write(lsact_pkg::CFG_SET_BITS, 5'd6);
        plan_write(lsact_pkg::CFG_BLOCK_BITS, 5'd25);
        plan_word(lsact_pkg::MODE_LOAD, 32'hFFFF_FFFF);
        plan_word(lsact_pkg::MODE_STORE, 32'h7E00_0000);
        plan_word(lsact_pkg::MODE_MODIFY, 32'hFE00_0000);

        foreach (directed_plan[k])
        begin
            if (directed_plan[k].is_write)
            begin
                settle_idle();
                write_register(directed_plan[k].reg_index, directed_plan[k].reg_value);
            end
            else
            begin
                send_word(directed_plan[k].word, pick_gap(), has, r);
                if (directed_plan[k].known)
                    pending_rsp.push_back(directed_plan[k].want);
                else if (has)
                    pending_rsp.push_back(r);
            end
        end

        // Random phases. Each phase writes new register values while idle and
        // then sends a burst of accesses. In some phases the sender also stops
        // midway until every owed response has come.
        phase      = 0;
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            settle_idle();
            calm = ($urandom_range(0, 4) == 0);
            write_register(lsact_pkg::CFG_SET_BITS, pick_index_bits());
            write_register(lsact_pkg::CFG_BLOCK_BITS, pick_block_bits());
            write_register(lsact_pkg::CFG_WAYS_USED, pick_ways());
            if ($urandom_range(0, 7) == 0)
                write_register(CFG_UNMAPPED, DATA_W'($urandom_range(0, 31)));
            phase_len = $urandom_range(40, 140);
            pause_at  = (phase == 1 || $urandom_range(0, 3) == 0)
                      ? $urandom_range(1, phase_len - 1) : -1;
            for (int i = 0; i < phase_len; i++)
            begin
                if (i == pause_at)
                    settle_idle();
                w.mode    = pick_mode();
                w.address = pick_address();
                send_word(w, pick_gap(), has, r);
                sent_items++;
                if (has)
                    pending_rsp.push_back(r);
            end
            phase++;
        end

        // Drain and give any stray response time to show up.
        calm = 1'b0;
        settle_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver side. Ready drops for mostly short stalls and a few long ones.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (calm)
            begin
                rsp_ready  <= 1'b1;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                rsp_ready  <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                rsp_ready  <= 1'b0;
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                        : $urandom_range(10, 60);
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Every response word taken is compared field by field with the oldest
    // owed one. Values are read at the edge, before this edge's updates land.
    always @(posedge clk)
    begin
        lsact_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_count++;
            if (pending_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Response %0d came with none owed: hit=%0b miss=%0b evict=%0b",
                             rsp_count, rsp.hit, rsp.miss, rsp.eviction);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.hit !== want.hit || rsp.miss !== want.miss
                    || rsp.eviction !== want.eviction || rsp.modify_hit !== want.modify_hit
                    || rsp.hit_total !== want.hit_total || rsp.miss_total !== want.miss_total
                    || rsp.evict_total !== want.evict_total)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("Response %0d expected h/m/e/mod %0b%0b%0b%0b totals %0d %0d %0d",
                                 rsp_count, want.hit, want.miss, want.eviction,
                                 want.modify_hit, want.hit_total, want.miss_total,
                                 want.evict_total);
                        $display("Response %0d actual   h/m/e/mod %0b%0b%0b%0b totals %0d %0d %0d",
                                 rsp_count, rsp.hit, rsp.miss, rsp.eviction,
                                 rsp.modify_hit, rsp.hit_total, rsp.miss_total,
                                 rsp.evict_total);
                    end
                end
            end
        end
    end

    // Hard stop for a hung handshake. It is far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
